FILE: rtl/visit_histogram_flatness_scan_top_assert.svh
// Assertion macros for the histogram flatness block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef VISIT_HISTOGRAM_FLATNESS_SCAN_TOP_ASSERT_SVH
`define VISIT_HISTOGRAM_FLATNESS_SCAN_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define VHFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define VHFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vhfs_pkg.sv
package vhfs_pkg;

  localparam int unsigned MAX_BINS_DEF   = 1024;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned Q16_FRAC       = 16;
  localparam logic [16:0] Q16_ONE        = 17'h10000;

  localparam logic [10:0] BINS_RST = 11'd1024;
  localparam logic [10:0] MINW_RST = 11'd16;
  localparam logic [16:0] CRIT_RST = 17'd52429;

  typedef enum logic [2:0] {
    OP_VISIT   = 3'd0,
    OP_DEFLATE = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_QUERY   = 3'd3,
    OP_SCAN    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    REG_BINS = 2'd0,
    REG_MINW = 2'd1,
    REG_CRIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  bin_index;
    logic [9:0]  range_low;
    logic [10:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [16:0] flatness;
    logic        is_flat;
    logic [10:0] area_low;
    logic [10:0] area_high;
  } res_t;

endpackage

FILE: rtl/vhfs_ram.sv
module vhfs_ram #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 2
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/vhfs_mul.sv
module vhfs_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned PW   = AW + BW;
  localparam int unsigned CNTW = $clog2(BW + 1);

  logic            run_q, run_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   acc_q, acc_d, mcand_q, mcand_d;
  logic [BW-1:0]   mplier_q, mplier_d;

  always_comb begin
    run_d    = run_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      run_d    = 1'b1;
      cnt_d    = CNTW'(BW);
      acc_d    = '0;
      mcand_d  = PW'(a_i);
      mplier_d = b_i;
    end else if (run_q) begin
      if (cnt_q != '0) begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[PW-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = run_q && (cnt_q == '0);
  assign prod_o = acc_q;

endmodule

FILE: rtl/vhfs_div.sv
module vhfs_div #(
  parameter int unsigned W = 42
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [16:0]  quo_o
);

  localparam int unsigned CNTW = $clog2(vhfs_pkg::Q16_FRAC + 1);

  logic            run_q, run_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    r_q, r_d, den_q, den_d;
  logic [16:0]     q_q, q_d;
  logic [W:0]      r2;
  logic [W:0]      diff;
  logic            ge;

  assign r2   = {r_q, 1'b0};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    r_d   = r_q;
    den_d = den_q;
    q_d   = q_q;
    if (start_i) begin
      run_d = 1'b1;
      den_d = den_i;
      r_d   = num_i;
      if (num_i >= den_i) begin
        q_d   = vhfs_pkg::Q16_ONE;
        cnt_d = '0;
      end else begin
        q_d   = '0;
        cnt_d = CNTW'(vhfs_pkg::Q16_FRAC);
      end
    end else if (run_q) begin
      if (cnt_q != '0) begin
        q_d   = {q_q[15:0], ge};
        r_d   = ge ? diff[W-1:0] : r2[W-1:0];
        cnt_d = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = q_q;

endmodule

FILE: rtl/visit_histogram_flatness_scan_top.sv
// Visit-count histogram with flatness query and flattest-window scan.
// Command channel: an item (cmd_i) is taken when start is high and busy is
// low. Each item answers with one result on result_o, marked by a one-cycle
// result_valid_o pulse; the receiver has no way to hold it off.
// Configuration: APB write/read of bins_in_use (0x0), min_window (0x4) and
// flat_criterion (0x8); the user must do so only while the block is idle;
// the block does not enforce it. Counts share one RAM with their set marks,
// deflated marks sit in a second one, both with a registered read. Visit
// and deflate read, then write; query and scan only read; clear only writes.
// Busy stays high while an item runs, so a new item is taken only once the
// last one is done. Clear sweeps the set marks. Query walks its range one
// bin a cycle, then a serial multiply where the range holds a set count, and
// a divide of up to 16 steps. Scan walks windows of min_window bins in turn,
// each one bin on from the last, with a serial multiply where the window
// holds a set count, two serial multiplies for each eligible window after
// the first, and a divide for the best one, if any, at the end.
// Reset: the set and deflated marks are swept to zero with busy high;
// configuration writes are taken during that sweep.
module visit_histogram_flatness_scan_top #(
  parameter int unsigned MAX_BINS   = vhfs_pkg::MAX_BINS_DEF,
  parameter int unsigned COUNT_BITS = vhfs_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vhfs_pkg::cmd_t  cmd_i,
  output logic            result_valid_o,
  output vhfs_pkg::res_t  result_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned IW   = $clog2(MAX_BINS);
  localparam int unsigned NW   = IW + 1;
  localparam int unsigned CW   = (NW > 11) ? NW : 11;
  localparam int unsigned SUMW = COUNT_BITS + IW;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RMW   = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_POST  = 4'd5;
  localparam logic [3:0] S_NUM   = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [CW-1:0]         cur_q, cur_d, hi_q, hi_d, l_q, l_d, w_q, w_d;
  logic                  pend_q, pend_d;
  logic [COUNT_BITS-1:0] mn_q, mn_d;
  logic [SUMW-1:0]       sum_q, sum_d, num_q, num_d, den_q, den_d, bn_q, bn_d, bd_q, bd_d;
  logic [NW-1:0]         n_q, n_d, sp_q, sp_d;
  logic                  found_q, found_d;
  logic [CW-1:0]         best_low_q, best_low_d, best_high_q, best_high_d;
  vhfs_pkg::res_t        res_q, res_d;
  logic                  res_valid_q, res_valid_d;
  logic [10:0]           bins_q, bins_d, minw_q, minw_d;
  logic [16:0]           crit_q, crit_d;

  logic [CW-1:0]         nb, bin_ext, rlo_ext, rhi_ext, minw_ext;
  logic [IW-1:0]         raddr;
  logic                  cnt_we, set_we, set_wd, defl_we, defl_wd;
  logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;
  logic                  set_rd, defl_rd;
  logic                  ram_we;
  logic [COUNT_BITS:0]   ram_wd, ram_rd;
  logic                  mul0_start, mulx_start, div_start;
  logic                  mul0_done, mul1_done, mul2_done, div_done;
  logic [SUMW:0]         mul0_prod;
  logic [2*SUMW-1:0]     mul1_prod, mul2_prod;
  logic [SUMW-1:0]       div_num, div_den;
  logic [16:0]           div_quo;
  logic                  eligible, cfg_wr;

  assign nb       = (CW'(bins_q) > CW'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(bins_q);
  assign bin_ext  = CW'(cmd_i.bin_index);
  assign rlo_ext  = CW'(cmd_i.range_low);
  assign rhi_ext  = CW'(cmd_i.range_high);
  assign minw_ext = CW'(minw_q);
  assign busy     = (state_q != S_IDLE);
  assign raddr    = (state_q == S_IDLE) ? bin_ext[IW-1:0] : cur_q[IW-1:0];
  assign eligible = (CW+1)'({sp_q, 1'b0}) < (CW+1)'(w_q);
  assign div_num  = (op_q == vhfs_pkg::OP_SCAN) ? bn_q : num_q;
  assign div_den  = (op_q == vhfs_pkg::OP_SCAN) ? bd_q : den_q;

  assign ram_we            = cnt_we || set_we;
  assign ram_wd            = {(set_we ? set_wd : set_rd), cnt_wd};
  assign {set_rd, cnt_rd}  = ram_rd;

  vhfs_ram #(.W(COUNT_BITS + 1), .D(MAX_BINS)) u_cnt_ram (
    .clk_i, .we_i(ram_we), .waddr_i(cur_q[IW-1:0]), .wdata_i(ram_wd),
    .raddr_i(raddr), .rdata_o(ram_rd)
  );

  vhfs_ram #(.W(1), .D(MAX_BINS)) u_defl_ram (
    .clk_i, .we_i(defl_we), .waddr_i(cur_q[IW-1:0]), .wdata_i(defl_wd),
    .raddr_i(raddr), .rdata_o(defl_rd)
  );

  vhfs_mul #(.AW(COUNT_BITS), .BW(NW)) u_mul_num (
    .clk_i, .rst_ni, .start_i(mul0_start), .a_i(mn_q), .b_i(n_q),
    .done_o(mul0_done), .prod_o(mul0_prod)
  );

  vhfs_mul #(.AW(SUMW), .BW(SUMW)) u_mul_cur (
    .clk_i, .rst_ni, .start_i(mulx_start), .a_i(num_q), .b_i(bd_q),
    .done_o(mul1_done), .prod_o(mul1_prod)
  );

  vhfs_mul #(.AW(SUMW), .BW(SUMW)) u_mul_best (
    .clk_i, .rst_ni, .start_i(mulx_start), .a_i(bn_q), .b_i(den_q),
    .done_o(mul2_done), .prod_o(mul2_prod)
  );

  vhfs_div #(.W(SUMW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    bins_d = bins_q;
    minw_d = minw_q;
    crit_d = crit_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        vhfs_pkg::REG_BINS: bins_d = pwdata[10:0];
        vhfs_pkg::REG_MINW: minw_d = pwdata[10:0];
        vhfs_pkg::REG_CRIT: crit_d = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vhfs_pkg::REG_BINS: prdata = 32'(bins_q);
      vhfs_pkg::REG_MINW: prdata = 32'(minw_q);
      vhfs_pkg::REG_CRIT: prdata = 32'(crit_q);
      default:            prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cur_d       = cur_q;
    hi_d        = hi_q;
    l_d         = l_q;
    w_d         = w_q;
    pend_d      = 1'b0;
    mn_d        = mn_q;
    sum_d       = sum_q;
    n_d         = n_q;
    sp_d        = sp_q;
    num_d       = num_q;
    den_d       = den_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    found_d     = found_q;
    best_low_d  = best_low_q;
    best_high_d = best_high_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    cnt_we      = 1'b0;
    cnt_wd      = cnt_rd;
    set_we      = 1'b0;
    set_wd      = 1'b0;
    defl_we     = 1'b0;
    defl_wd     = 1'b0;
    mul0_start  = 1'b0;
    mulx_start  = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      S_INIT: begin
        set_we  = 1'b1;
        defl_we = 1'b1;
        if (cur_q == CW'(MAX_BINS - 1)) begin
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          res_d = '0;
          op_d  = cmd_i.opcode;
          cur_d = bin_ext;
          mn_d  = '1;
          sum_d = '0;
          n_d   = '0;
          sp_d  = '0;
          unique case (cmd_i.opcode) inside
            vhfs_pkg::OP_VISIT, vhfs_pkg::OP_DEFLATE: begin
              if (bin_ext >= nb) begin
                res_d.status = 1'b1;
                res_valid_d  = 1'b1;
              end else begin
                state_d = S_RMW;
              end
            end
            vhfs_pkg::OP_CLEAR: begin
              cur_d   = '0;
              state_d = S_CLEAR;
            end
            vhfs_pkg::OP_QUERY: begin
              if (rlo_ext >= rhi_ext || rhi_ext > nb) begin
                res_d.status = 1'b1;
                res_valid_d  = 1'b1;
              end else begin
                cur_d   = rlo_ext;
                hi_d    = rhi_ext;
                state_d = S_WALK;
              end
            end
            vhfs_pkg::OP_SCAN: begin
              w_d     = minw_ext;
              found_d = 1'b0;
              if (minw_ext < nb) begin
                l_d     = '0;
                cur_d   = '0;
                hi_d    = minw_ext;
                state_d = S_WALK;
              end else begin
                best_low_d  = '0;
                best_high_d = '0;
                res_valid_d = 1'b1;
              end
            end
            default: begin
              res_d.status = 1'b1;
              res_valid_d  = 1'b1;
            end
          endcase
        end
      end
      S_RMW: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        if (op_q == vhfs_pkg::OP_DEFLATE) begin
          defl_we = 1'b1;
          defl_wd = 1'b1;
          set_we  = 1'b1;
          set_wd  = 1'b0;
        end else if (defl_rd) begin
          res_d.status = 1'b1;
        end else if (!set_rd) begin
          cnt_we = 1'b1;
          cnt_wd = COUNT_BITS'(1);
          set_we = 1'b1;
          set_wd = 1'b1;
        end else if (cnt_rd != '1) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_rd + 1'b1;
        end
      end
      S_CLEAR: begin
        set_we = 1'b1;
        if (cur_q == CW'(MAX_BINS - 1)) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      S_WALK: begin
        if (cur_q != hi_q) begin
          pend_d = 1'b1;
          cur_d  = cur_q + 1'b1;
        end
        if (pend_q) begin
          if (defl_rd || !set_rd) begin
            sp_d = sp_q + 1'b1;
          end
          if (set_rd) begin
            if (cnt_rd < mn_q) begin
              mn_d = cnt_rd;
            end
            sum_d = sum_q + SUMW'(cnt_rd);
            n_d   = n_q + 1'b1;
          end
        end
        if (cur_q == hi_q && !pend_q) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (n_q == '0 || sum_q == '0) begin
          num_d   = '0;
          den_d   = SUMW'(1);
          state_d = S_EVAL;
        end else begin
          den_d      = sum_q;
          mul0_start = 1'b1;
          state_d    = S_NUM;
        end
      end
      S_NUM: begin
        if (mul0_done) begin
          num_d   = mul0_prod[SUMW-1:0];
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_q == vhfs_pkg::OP_QUERY) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (eligible && !found_q) begin
          found_d     = 1'b1;
          bn_d        = num_q;
          bd_d        = den_q;
          best_low_d  = l_q;
          best_high_d = hi_q;
          state_d     = S_NEXT;
        end else if (eligible) begin
          mulx_start = 1'b1;
          state_d    = S_CMP;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_CMP: begin
        if (mul1_done && mul2_done) begin
          if (mul1_prod > mul2_prod) begin
            bn_d        = num_q;
            bd_d        = den_q;
            best_low_d  = l_q;
            best_high_d = hi_q;
          end
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (hi_q + 1'b1 < nb) begin
          l_d     = l_q + 1'b1;
          cur_d   = l_q + 1'b1;
          hi_d    = hi_q + 1'b1;
          mn_d    = '1;
          sum_d   = '0;
          n_d     = '0;
          sp_d    = '0;
          state_d = S_WALK;
        end else if (found_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          best_low_d  = '0;
          best_high_d = '0;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.flatness = div_quo;
          res_d.is_flat  = div_quo >= crit_q;
          if (op_q == vhfs_pkg::OP_SCAN) begin
            res_d.area_low  = best_low_q[10:0];
            res_d.area_high = best_high_q[10:0];
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      best_low_q  <= '0;
      best_high_q <= '0;
      res_valid_q <= 1'b0;
      bins_q      <= vhfs_pkg::BINS_RST;
      minw_q      <= vhfs_pkg::MINW_RST;
      crit_q      <= vhfs_pkg::CRIT_RST;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      best_low_q  <= best_low_d;
      best_high_q <= best_high_d;
      res_valid_q <= res_valid_d;
      bins_q      <= bins_d;
      minw_q      <= minw_d;
      crit_q      <= crit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    hi_q  <= hi_d;
    l_q   <= l_d;
    w_q   <= w_d;
    mn_q  <= mn_d;
    sum_q <= sum_d;
    n_q   <= n_d;
    sp_q  <= sp_d;
    num_q <= num_d;
    den_q <= den_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`include "visit_histogram_flatness_scan_top_assert.svh"

  `VHFS_ASSERT_NEXT(a_accept_works, start && !busy, busy || result_valid_o, "accepted item dropped")
  `VHFS_ASSERT_NOW(a_result_follows, result_valid_o, $past(busy || start), "result without item")
  `VHFS_ASSERT_NOW(a_walk_bound, state_q == S_WALK, cur_q <= hi_q, "walk ran past its end")
  `VHFS_ASSERT_NOW(a_err_clean, result_valid_o && result_o.status, result_o.flatness == '0 && result_o.area_high == '0, "error result carries data")

endmodule
